FILE: rtl/core/mod_exp_pkg.sv
package mod_exp_pkg;

  // Width of the operand fields on the ports.
  localparam int FIELD_WIDTH = 32;

  // Default internal operand width.
  localparam int OPERAND_WIDTH_DEF = 32;

  // Configuration register indexes.
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  // Register values after reset.
  localparam logic [FIELD_WIDTH-1:0] EXPONENT_RESET = 32'd65537;
  localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET  = 32'd4294967291;

endpackage

FILE: rtl/core/modular_exponentiation.sv
// Raises each input word to the power held in the exponent register, modulo
// the modulus register, by right-to-left square-and-multiply. Every modular
// product goes through one bit-serial shift-and-add reducer that doubles and
// then conditionally adds for each of the OPERAND_WIDTH multiplier bits. An
// item costs one product to reduce the base, then, for every exponent bit up
// to the highest set one, one product for a set bit and one squaring except
// after the highest set bit, plus taking the word in and handing over the
// result. A zero exponent gives 1; otherwise a modulus below two gives 0;
// both skip the reducer. One item is worked on at a time; the next may enter
// while the previous result waits in the output register. Configuration
// writes are taken only while the block is idle.
module modular_exponentiation
  import mod_exp_pkg::*;
#(
  parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic                   cfg_index,
  input  logic [FIELD_WIDTH-1:0] cfg_data,
  // Input words.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [FIELD_WIDTH-1:0] s_tdata,   // [31:0] base_value
  // Result words.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [FIELD_WIDTH-1:0] m_tdata    // [31:0] power_result
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_REDUCE  = 5'b00010,
    ST_MUL_ACC = 5'b00100,
    ST_MUL_SQ  = 5'b01000,
    ST_FINISH  = 5'b10000
  } state_t;

  state_t         state;
  logic [W-1:0]   exponent;
  logic [W-1:0]   modulus;
  logic [W-1:0]   exp_sh;
  logic [W-1:0]   acc;
  logic [W-1:0]   sq;
  logic [W-1:0]   result;

  // Serial reducer registers.
  logic [W-1:0]   mul_a;
  logic [W-1:0]   mul_b;
  logic [W-1:0]   mul_r;
  logic [CW-1:0]  mul_cnt;
  logic           mul_phase;

  logic [W-1:0]   mul_addend;
  logic [W:0]     mul_t;
  logic [W+1:0]   mul_d;
  logic [W-1:0]   mul_r_next;
  logic           mul_done;
  logic           in_mul;
  logic [W-1:0]   base_in;

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);
  assign base_in   = s_tdata[W-1:0];
  assign in_mul    = (state == ST_REDUCE) || (state == ST_MUL_ACC) || (state == ST_MUL_SQ);

  // One reducer step: doubling in phase zero, conditional add in phase one,
  // each followed by a single trial subtraction of the modulus.
  always_comb begin
    mul_addend = mul_b[W-1] ? mul_a : '0;
    if (mul_phase) begin
      mul_t = {1'b0, mul_r} + {1'b0, mul_addend};
    end else begin
      mul_t = {mul_r, 1'b0};
    end
    mul_d      = {1'b0, mul_t} - {2'b00, modulus};
    mul_r_next = mul_d[W+1] ? mul_t[W-1:0] : mul_d[W-1:0];
    mul_done   = mul_phase && (mul_cnt == '0);
  end

  // Sequencer, reducer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      exponent  <= EXPONENT_RESET[W-1:0];
      modulus   <= MODULUS_RESET[W-1:0];
      mul_phase <= 1'b0;
    end else begin
      if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      // Reducer stepping while a product is in progress.
      if (in_mul) begin
        mul_r     <= mul_r_next;
        mul_phase <= ~mul_phase;
        if (mul_phase) begin
          mul_b   <= {mul_b[W-2:0], 1'b0};
          mul_cnt <= mul_cnt - 1'b1;
        end
      end

      case (state)
        ST_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index == REG_EXPONENT) begin
              exponent <= cfg_data[W-1:0];
            end else begin
              modulus <= cfg_data[W-1:0];
            end
          end
          if (s_tvalid) begin
            exp_sh <= exponent;
            acc    <= W'(1);
            if (exponent == '0) begin
              result <= W'(1);
              state  <= ST_FINISH;
            end else if (modulus < W'(2)) begin
              result <= '0;
              state  <= ST_FINISH;
            end else begin
              // Horner reduction of the base: base * 1 mod m.
              mul_a     <= W'(1);
              mul_b     <= base_in;
              mul_r     <= '0;
              mul_cnt   <= CW'(W - 1);
              mul_phase <= 1'b0;
              state     <= ST_REDUCE;
            end
          end
        end

        ST_REDUCE: begin
          if (mul_done) begin
            sq        <= mul_r_next;
            mul_a     <= mul_r_next;
            mul_r     <= '0;
            mul_cnt   <= CW'(W - 1);
            mul_phase <= 1'b0;
            if (exp_sh[0]) begin
              mul_b <= acc;
              state <= ST_MUL_ACC;
            end else begin
              mul_b <= mul_r_next;
              state <= ST_MUL_SQ;
            end
          end
        end

        ST_MUL_ACC: begin
          if (mul_done) begin
            acc <= mul_r_next;
            if (exp_sh[W-1:1] == '0) begin
              result <= mul_r_next;
              state  <= ST_FINISH;
            end else begin
              mul_a     <= sq;
              mul_b     <= sq;
              mul_r     <= '0;
              mul_cnt   <= CW'(W - 1);
              mul_phase <= 1'b0;
              state     <= ST_MUL_SQ;
            end
          end
        end

        ST_MUL_SQ: begin
          if (mul_done) begin
            sq        <= mul_r_next;
            exp_sh    <= {1'b0, exp_sh[W-1:1]};
            mul_a     <= mul_r_next;
            mul_r     <= '0;
            mul_cnt   <= CW'(W - 1);
            mul_phase <= 1'b0;
            if (exp_sh[W-1:1] == '0) begin
              result <= acc;
              state  <= ST_FINISH;
            end else if (exp_sh[1]) begin
              mul_b <= acc;
              state <= ST_MUL_ACC;
            end else begin
              mul_b <= mul_r_next;
              state <= ST_MUL_SQ;
            end
          end
        end

        ST_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= FIELD_WIDTH'(result);
            state    <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The running remainder never reaches the modulus.
  a_rem_below_mod: assert property (@(posedge clk) disable iff (rst)
    in_mul |-> (mul_r < modulus))
    else $error("reducer remainder not below modulus");

  // The multiplicand handed to the reducer is always reduced.
  a_mcand_below_mod: assert property (@(posedge clk) disable iff (rst)
    in_mul |-> (mul_a < modulus))
    else $error("reducer multiplicand not below modulus");

  // A new result word only appears when the sequencer hands one over.
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == ST_FINISH))
    else $error("result word raised outside hand-over");

  // An accepted word always takes the block out of idle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state != ST_IDLE))
    else $error("accepted word did not start work");

endmodule

FILE: test/modular_exponentiation_tb.sv
module modular_exponentiation_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mod_exp_pkg::*;

  localparam int HALF_PERIOD   = 5;
  localparam int RESET_CYCLES  = 3;
  localparam int SETTLE_CYCLES = 16;
  localparam int END_CYCLES    = 100;
  localparam int KEY_PHASES    = 9;
  localparam int PHASE_WORDS   = 30;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic                   cfg_index = REG_EXPONENT;
  logic [FIELD_WIDTH-1:0] cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [FIELD_WIDTH-1:0] s_tdata = '0;   // [31:0] base_value
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [FIELD_WIDTH-1:0] m_tdata;        // [31:0] power_result

  // Local copy of the key registers, tracking every accepted write.
  logic [FIELD_WIDTH-1:0] exponent_shadow = EXPONENT_RESET;
  logic [FIELD_WIDTH-1:0] modulus_shadow  = MODULUS_RESET;

  logic [FIELD_WIDTH-1:0] pending_powers[$];
  logic [FIELD_WIDTH-1:0] wanted_power;
  int                     mismatch_count = 0;
  int                     stall_left = 0;
  logic                   idle_on = 1'b1;

  modular_exponentiation uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // Right-to-left square-and-multiply on 64-bit intermediates.
  function automatic logic [FIELD_WIDTH-1:0] predict_power(input logic [FIELD_WIDTH-1:0] base,
                                                           input logic [FIELD_WIDTH-1:0] expo,
                                                           input logic [FIELD_WIDTH-1:0] modv);
    logic [63:0] acc;
    logic [63:0] square;
    logic [63:0] m64;
    if (expo == '0) begin
      return 1;
    end
    if (modv == '0) begin
      return 0;
    end
    m64 = {32'd0, modv};
    square = {32'd0, base} % m64;
    acc = 64'd1 % m64;
    for (int i = 0; i < FIELD_WIDTH; i++) begin
      if (expo[i]) begin
        acc = (acc * square) % m64;
      end
      square = (square * square) % m64;
    end
    return acc[FIELD_WIDTH-1:0];
  endfunction

  // Result side: random bursts of back-pressure while idling is enabled.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 15) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Each delivered word is compared with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid === 1'b1 && m_tready) begin
      if (pending_powers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word, expected none, actual 0x%08h", $time, m_tdata);
      end else begin
        wanted_power = pending_powers.pop_front();
        if (m_tdata !== wanted_power) begin
          mismatch_count++;
          $display("%0t: power_result mismatch, expected 0x%08h, actual 0x%08h",
                   $time, wanted_power, m_tdata);
        end
      end
    end
  end

  // Sends one base word, sometimes after a gap, and records its prediction.
  task automatic send_base(input logic [FIELD_WIDTH-1:0] base);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 17);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= base;
    do @(posedge clk); while (!s_tready);
    pending_powers.push_back(predict_power(base, exponent_shadow, modulus_shadow));
  endtask

  // Stops the input stream and lets every outstanding result come back.
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_powers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic idx, input logic [FIELD_WIDTH-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_EXPONENT) begin
      exponent_shadow = value;
    end else begin
      modulus_shadow = value;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Key values straight out of reset.
  task automatic test_reset_keys();
    send_base(32'd0);
    send_base(32'd1);
    send_base(32'd2);
    send_base(32'hFFFF_FFFF);
    send_base(MODULUS_RESET);
    send_base(MODULUS_RESET - 1);
  endtask

  // A zero exponent gives one, unreduced, whatever the modulus.
  task automatic test_zero_exponent();
    write_register(REG_EXPONENT, 32'd0);
    write_register(REG_MODULUS, 32'hFFFF_FFFF);
    send_base(32'hFFFF_FFFF);
    send_base(32'd12345);
    write_register(REG_MODULUS, 32'd1);
    send_base(32'd5);
    write_register(REG_MODULUS, 32'd0);
    send_base(32'd7);
  endtask

  // Moduli of zero and one give zero; two is the smallest real reduction.
  task automatic test_tiny_modulus();
    write_register(REG_EXPONENT, 32'hFFFF_FFFF);
    write_register(REG_MODULUS, 32'd1);
    send_base(32'd9);
    write_register(REG_MODULUS, 32'd0);
    send_base(32'd9);
    write_register(REG_EXPONENT, 32'd3);
    write_register(REG_MODULUS, 32'd2);
    send_base(32'd3);
    send_base(32'd4);
  endtask

  // Smallest, largest and single-top-bit exponents.
  task automatic test_exponent_extremes();
    write_register(REG_EXPONENT, 32'd1);
    write_register(REG_MODULUS, 32'hFFFF_FFFF);
    send_base(32'hFFFF_FFFF);
    send_base(32'hFFFF_FFFE);
    write_register(REG_EXPONENT, 32'hFFFF_FFFF);
    write_register(REG_MODULUS, 32'hFFFF_FFFB);
    send_base(32'd2);
    send_base(32'hDEAD_BEEF);
    write_register(REG_EXPONENT, 32'h8000_0000);
    write_register(REG_MODULUS, 32'd1000003);
    send_base(32'hAAAA_AAAA);
    send_base(32'h5555_5555);
  endtask

  // Random keys, mostly short exponents to keep each word fast; the last
  // phase runs without any idling.
  task automatic test_random_keys();
    logic [FIELD_WIDTH-1:0] expo;
    logic [FIELD_WIDTH-1:0] modv;
    logic [FIELD_WIDTH-1:0] base;
    int                     w;
    for (int phase = 0; phase < KEY_PHASES; phase++) begin
      case ($urandom_range(0, 9))
        0: expo = $urandom;
        1: expo = $urandom_range(0, 1);
        default: begin
          w = $urandom_range(2, 17);
          expo = ($urandom & ((32'd1 << w) - 1)) | (32'd1 << (w - 1));
        end
      endcase
      case ($urandom_range(0, 3))
        0: modv = $urandom_range(2, 1000);
        1: modv = $urandom | 32'h8000_0000;
        default: modv = $urandom;
      endcase
      if (modv < 2) begin
        modv = 2;
      end
      write_register(REG_EXPONENT, expo);
      write_register(REG_MODULUS, modv);
      idle_on = (phase == KEY_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(0, 5))
          0: base = modv - $urandom_range(0, 1);
          1: base = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : $urandom_range(0, 2);
          2: base = $urandom % modv;
          default: base = $urandom;
        endcase
        send_base(base);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_keys();
    test_zero_exponent();
    test_tiny_modulus();
    test_exponent_extremes();
    test_random_keys();
    wait_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_powers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Generous ceiling: several times the slowest legal run.
  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
